// ===== rtl/symhist_pkg.sv =====
// Shared constants and types for the symbol histogram unit.
`timescale 1ns / 1ps
`default_nettype none

package symhist_pkg;

	// Table geometry
	localparam int SYMBOLS     = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int SYM_W       = 8;
	localparam int IDX_W       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

	// Beat fields
	localparam int CMD_W       = 2;
	localparam int BIN_W       = 32;
	localparam int DIST_W      = 9;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;
	localparam int EXT_W       = (COUNT_WIDTH > BIN_W) ? COUNT_WIDTH : BIN_W;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [SYM_W-1:0] GAP_SYMBOL = 8'h2D;
	localparam logic [SYM_W:0]   SYM_LIMIT  = (SYM_W + 1)'(SYMBOLS);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_READ,
		OP_CLEAR
	} op_t;

	// One classified item as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic             in_range;
		logic             is_gap;
		logic [IDX_W-1:0] idx;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/symbol_histogram_unit.sv =====
// Top level of the symbol histogram unit: front queue plus bin update back end.
`timescale 1ns / 1ps
`default_nettype none

// Counts byte symbols. Each input beat carries a command (add, read, clear) and a
// symbol; each produces exactly one result beat with the symbol's count after the
// step (saturating), the number of distinct symbols since the last clear and a flag
// for a counted '-' symbol. Input beats enter a four-entry queue, so the input side
// keeps taking beats while the result side stalls, until the queue is full. The back end handles
// one item at a time and takes no new one before it is done: the registered read of the bin
// memory, then the update, write-back and loading of the result register, which waits while an
// earlier result beat stalls. Clear takes effect at once through per-bin valid bits; no clearing pass after reset.
module symbol_histogram_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] command, [9:2] symbol, [15:10] zero
	input  wire  [symhist_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [31:0] bin_count, [40:32] distinct_symbols, [41] gap_seen, [47:42] zero
	output logic [symhist_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import symhist_pkg::*;

	item_t head;
	logic  head_valid;
	logic  pop;

	symhist_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop)
	);

	symhist_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/symhist_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module symhist_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// [1:0] command, [9:2] symbol, [15:10] zero
	input  wire  [symhist_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output symhist_pkg::item_t                 head,
	output logic                               head_valid,
	input  wire                                pop
);
	import symhist_pkg::*;

	logic [CMD_W-1:0]  command;
	logic [SYM_W-1:0]  symbol;
	item_t             item;
	logic              push;
	item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign command = s_axis_tdata[CMD_W-1:0];
	assign symbol  = s_axis_tdata[CMD_W+SYM_W-1:CMD_W];

	// Classify: unused command code behaves as a read
	always_comb begin
		case (command)
			CMD_ADD:   item.op = OP_ADD;
			CMD_CLEAR: item.op = OP_CLEAR;
			default:   item.op = OP_READ;
		endcase
		item.in_range = {1'b0, symbol} < SYM_LIMIT;
		item.is_gap   = (symbol == GAP_SYMBOL);
		item.idx      = symbol[IDX_W-1:0];
	end

	assign s_axis_tready = (fill_q != QCNT_W'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (fill_q != '0);
	assign head          = entries_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/symhist_back.sv =====
// Back end: bin memory read-modify-write, valid bits, totals and the result register.
`timescale 1ns / 1ps
`default_nettype none

module symhist_back (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  symhist_pkg::item_t                  head,
	input  wire                                 head_valid,
	output logic                                pop,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [31:0] bin_count, [40:32] distinct_symbols, [41] gap_seen, [47:42] zero
	output logic [symhist_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import symhist_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [EXT_W-1:0]       BIN_MAX   = EXT_W'({BIN_W{1'b1}});

	logic                   state_q;
	item_t                  item_s1;
	logic [COUNT_WIDTH-1:0] rd_data_s1;
	logic [COUNT_WIDTH-1:0] mem [SYMBOLS];
	logic [SYMBOLS-1:0]     valid_q;
	logic [DIST_W-1:0]      distinct_q;
	logic                   gap_q;
	logic                   out_valid_q;
	logic [BIN_W-1:0]       out_bin_q;
	logic [DIST_W-1:0]      out_dist_q;
	logic                   out_gap_q;

	logic                   fire;
	logic                   hit;
	logic                   mem_we;
	logic                   set_valid;
	logic [COUNT_WIDTH-1:0] count;
	logic [DIST_W-1:0]      dist_next;
	logic                   gap_next;
	logic [EXT_W-1:0]       count_ext;
	logic [BIN_W-1:0]       bin_out;

	assign pop  = (state_q == ST_IDLE) && head_valid;
	assign fire = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
	assign hit  = item_s1.in_range && valid_q[item_s1.idx];

	// Update of the selected bin and the totals
	always_comb begin
		mem_we    = 1'b0;
		set_valid = 1'b0;
		count     = '0;
		dist_next = distinct_q;
		gap_next  = gap_q;
		case (item_s1.op)
			OP_ADD: begin
				if (item_s1.in_range) begin
					mem_we = fire;
					if (!hit) begin
						count     = COUNT_WIDTH'(1);
						set_valid = fire;
						dist_next = distinct_q + 1'b1;
					end else if (rd_data_s1 != COUNT_MAX) begin
						count = rd_data_s1 + 1'b1;
					end else begin
						count = rd_data_s1;
					end
					if (item_s1.is_gap) begin
						gap_next = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (hit) begin
					count = rd_data_s1;
				end
			end
			OP_CLEAR: begin
				dist_next = '0;
				gap_next  = 1'b0;
			end
			default: begin
				count = '0;
			end
		endcase
		count_ext = EXT_W'(count);
		bin_out   = (count_ext > BIN_MAX) ? {BIN_W{1'b1}} : count_ext[BIN_W-1:0];
	end

	// Bin memory and stage-1 capture
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[item_s1.idx] <= count;
		end
		if (pop) begin
			rd_data_s1 <= mem[head.idx];
			item_s1    <= head;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_bin_q  <= bin_out;
			out_dist_q <= dist_next;
			out_gap_q  <= gap_next;
		end
	end

	// Control, valid bits and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			distinct_q  <= '0;
			gap_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				distinct_q <= dist_next;
				gap_q      <= gap_next;
				if (item_s1.op == OP_CLEAR) begin
					valid_q <= '0;
				end else if (set_valid) begin
					valid_q[item_s1.idx] <= 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - BIN_W - DIST_W - 1)'(0), out_gap_q, out_dist_q, out_bin_q};

endmodule

`default_nettype wire

// ===== rtl/symhist_checker.sv =====
// Port-level checks for the symbol histogram unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module symhist_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [47:0] m_axis_tdata
);

	// Result beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// No result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// A gap can only be flagged once some symbol was counted
	a_gap_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[41] |-> m_axis_tdata[40:32] != 9'd0)
		else $error("gap flag with empty table");

	// A nonzero count needs a counted symbol and the total stays in range
	a_count_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:0] == 32'd0 || m_axis_tdata[40:32] != 9'd0)
			&& m_axis_tdata[40:32] <= 9'd256)
		else $error("distinct total inconsistent with bin count");

endmodule

bind symbol_histogram_unit symhist_checker u_checker (.*);

`default_nettype wire
